// ===== rtl/rmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Running median tracker package
// Shared types, sizes and elaboration-time helpers for the sorted cell chain
// and the registered median readout tree.
// ----------------------------------------------------------------------------
`default_nettype none

package rmt_pkg;

  // Number of sorted cells, i.e. the largest set that can be held.
  localparam int CAPACITY = 1024;

  localparam int SAMPLE_W = 16;
  // Count must be able to hold CAPACITY itself.
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Fan-in of each node in the median readout tree.
  localparam int RADIX    = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]           count_t;
  typedef logic [IDX_W-1:0]           index_t;

  // Per-cell control, decoded once per cell from the shared count.
  typedef struct packed {
    logic load;      // an item is being inserted this cycle
    logic occupied;  // the cell holds one of the stored samples
    logic at_end;    // the cell is the first free slot
  } cell_ctl_t;

  // Node count of a tree level; level 0 are the cells themselves.
  function automatic int level_nodes(input int lvl);
    int n;
    n = CAPACITY;
    for (int k = 0; k < lvl; k++) begin
      n = (n + RADIX - 1) / RADIX;
    end
    return n;
  endfunction

  // Levels needed to reduce all cells to a single node.
  function automatic int tree_depth();
    int n;
    int d;
    n = CAPACITY;
    d = 0;
    while (n > 1) begin
      n = (n + RADIX - 1) / RADIX;
      d = d + 1;
    end
    return (d < 1) ? 1 : d;
  endfunction

  localparam int TREE_LEVELS = tree_depth();

  // Position of the first node of a level (from 1) in the flat node array.
  function automatic int level_offset(input int lvl);
    int s;
    s = 0;
    for (int k = 1; k < lvl; k++) begin
      s = s + level_nodes(k);
    end
    return s;
  endfunction

  localparam int TREE_NODES = level_offset(TREE_LEVELS + 1);
  localparam int ROOT_NODE  = level_offset(TREE_LEVELS);

endpackage

`default_nettype wire

// ===== rtl/rmt_cell.sv =====
// ----------------------------------------------------------------------------
// Running median tracker sorted cell
// One slot of the ascending chain: compares its value with the new sample and
// either keeps it, takes its lower neighbour's value or takes the sample.
// ----------------------------------------------------------------------------
`default_nettype none

module rmt_cell (
  input  wire logic               clk,
  input  wire rmt_pkg::cell_ctl_t ctl_i,
  input  wire rmt_pkg::sample_t   sample_i,
  input  wire rmt_pkg::sample_t   prev_val_i,
  input  wire logic               prev_gt_i,
  output rmt_pkg::sample_t        val_o,
  output logic                    gt_o
);

  rmt_pkg::sample_t val_r;
  rmt_pkg::sample_t val_nxt;
  logic             write;

  // A stored value above the sample moves up by one slot.
  assign gt_o  = ctl_i.occupied && (val_r > sample_i);
  assign write = ctl_i.load && (gt_o || ctl_i.at_end);

  always_comb begin
    val_nxt = val_r;
    if (write) begin
      val_nxt = prev_gt_i ? prev_val_i : sample_i;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;

endmodule

`default_nettype wire

// ===== rtl/rmt_node.sv =====
// ----------------------------------------------------------------------------
// Running median tracker readout node
// Registered OR of a group of masked values; only one input in the whole tree
// is non-zero, so the OR passes the selected value towards the root.
// ----------------------------------------------------------------------------
`default_nettype none

module rmt_node (
  input  wire logic                                            clk,
  input  wire logic                                            adv_i,
  input  wire logic [rmt_pkg::RADIX-1:0][rmt_pkg::SAMPLE_W-1:0] kids_i,
  output logic [rmt_pkg::SAMPLE_W-1:0]                         sum_o
);

  logic [rmt_pkg::SAMPLE_W-1:0] sum_r;
  logic [rmt_pkg::SAMPLE_W-1:0] sum_nxt;

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < rmt_pkg::RADIX; k++) begin
      sum_nxt = sum_nxt | kids_i[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_o = sum_r;

endmodule

`default_nettype wire

// ===== rtl/running_median_tracker.sv =====
// ----------------------------------------------------------------------------
// Running median tracker
// Keeps up to CAPACITY samples accepted since reset in ascending order and
// returns the lower median of the stored set for each item.
// ----------------------------------------------------------------------------
// Each input item carries one signed 16-bit sample; each produces exactly one
// result item with the lower median of all samples accepted so far and a flag
// that is set when the sample was dropped because the store already held
// CAPACITY samples (the median then refers to the unchanged set). Samples are
// held in a chain of CAPACITY identical cells kept in ascending order: on an
// insert every cell compares its value with the new sample in parallel, and
// the cells above the insertion point take their lower neighbour's value, so
// an insert is one parallel register update. The median is then read out
// through a registered OR tree of fan-in eight, with four levels for 1024
// cells (TREE_LEVELS); out_valid for a result rises once its item has passed
// the chain update and every tree level. The chain and the tree advance
// together, so one item is accepted every cycle while the result side keeps
// taking items; when a result is waiting and out_ready is low the whole
// pipeline holds and in_ready drops with it.
// No clearing pass is needed after reset; cells above the count are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_tracker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_median,
  output logic                    out_store_full
);

  localparam int LEVELS = rmt_pkg::TREE_LEVELS;

  // Pipeline control: the chain update is stage 0, each tree level one more.
  logic                advance;
  logic                accept;
  logic [LEVELS:0]     vld_r;
  logic [LEVELS:0]     full_r;

  // Count of stored samples and the sorted index of the current median.
  rmt_pkg::count_t     count_r;
  rmt_pkg::count_t     count_nxt;
  rmt_pkg::count_t     median_pos;
  rmt_pkg::index_t     sel_r;
  rmt_pkg::index_t     sel_nxt;
  logic                store_is_full;

  // Chain wiring.
  rmt_pkg::sample_t    cell_val [rmt_pkg::CAPACITY];
  logic                cell_gt  [rmt_pkg::CAPACITY];
  logic [rmt_pkg::SAMPLE_W-1:0] leaf_val [rmt_pkg::CAPACITY];

  // Outputs of every readout tree node, level by level.
  logic [rmt_pkg::SAMPLE_W-1:0] tree_q [rmt_pkg::TREE_NODES];

  // The whole pipeline moves when the result register is empty or being taken.
  assign advance  = !vld_r[LEVELS] || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  assign store_is_full = (count_r == rmt_pkg::count_t'(rmt_pkg::CAPACITY));

  always_comb begin
    count_nxt = count_r;
    if (accept && !store_is_full) begin
      count_nxt = count_r + rmt_pkg::count_t'(1);
    end
  end

  // Lower median sits at (count - 1) / 2; the count is never zero after an
  // item, and the selection is ignored until then.
  assign median_pos = (count_nxt - rmt_pkg::count_t'(1)) >> 1;
  assign sel_nxt    = median_pos[rmt_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sel_r   <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Sorted cell chain.
  for (genvar i = 0; i < rmt_pkg::CAPACITY; i++) begin : g_cell
    rmt_pkg::cell_ctl_t ctl;
    rmt_pkg::sample_t   prev_val;
    logic               prev_gt;

    assign ctl.load     = accept && !store_is_full;
    assign ctl.occupied = (count_r > rmt_pkg::count_t'(i));
    assign ctl.at_end   = (count_r == rmt_pkg::count_t'(i));

    if (i == 0) begin : g_first
      assign prev_val = in_sample;
      assign prev_gt  = 1'b0;
    end else begin : g_rest
      assign prev_val = cell_val[i-1];
      assign prev_gt  = cell_gt[i-1];
    end

    rmt_cell u_cell (
      .clk        (clk),
      .ctl_i      (ctl),
      .sample_i   (in_sample),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i])
    );

    // Only the median cell drives a non-zero value into the tree.
    assign leaf_val[i] = (sel_r == rmt_pkg::index_t'(i)) ? cell_val[i] : '0;
  end

  // Registered readout tree.
  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    for (genvar j = 0; j < rmt_pkg::level_nodes(l); j++) begin : g_node
      logic [rmt_pkg::RADIX-1:0][rmt_pkg::SAMPLE_W-1:0] kids;

      for (genvar k = 0; k < rmt_pkg::RADIX; k++) begin : g_kid
        localparam int C = j * rmt_pkg::RADIX + k;
        if (C >= rmt_pkg::level_nodes(l - 1)) begin : g_pad
          assign kids[k] = '0;
        end else if (l == 1) begin : g_leaf
          assign kids[k] = leaf_val[C];
        end else begin : g_inner
          assign kids[k] = tree_q[rmt_pkg::level_offset(l - 1) + C];
        end
      end

      rmt_node u_node (
        .clk    (clk),
        .adv_i  (advance),
        .kids_i (kids),
        .sum_o  (tree_q[rmt_pkg::level_offset(l) + j])
      );
    end
  end

  // Item tracking alongside the tree; the full flag travels with its item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[LEVELS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      full_r <= {full_r[LEVELS-1:0], store_is_full};
    end
  end

  assign out_valid      = vld_r[LEVELS];
  assign out_median     = tree_q[rmt_pkg::ROOT_NODE];
  assign out_store_full = full_r[LEVELS];

endmodule

`default_nettype wire
